@@ hdl/drm_pkg.sv @@
package drm_pkg;

    // Screen and table geometry.
    localparam int SCREEN_W  = 512;
    localparam int SCREEN_H  = 512;
    localparam int MAX_RECTS = 16;

    // Field widths.
    localparam int IN_W     = 16;
    localparam int EDGE_W   = 10;
    localparam int IDX_W    = $clog2(MAX_RECTS);
    localparam int CNT_W    = $clog2(MAX_RECTS + 1);
    localparam int AREA_W   = 23;
    localparam int SLACK_W  = 16;
    localparam int EAREA_W  = 2 * EDGE_W;
    localparam int LIMIT_W  = EAREA_W + 2;
    localparam int BOX_W    = 4 * EDGE_W;

    localparam logic signed [IN_W-1:0] SCREEN_W_S = IN_W'(SCREEN_W);
    localparam logic signed [IN_W-1:0] SCREEN_H_S = IN_W'(SCREEN_H);
    localparam logic [AREA_W-1:0]      SCREEN_AREA = AREA_W'(SCREEN_W * SCREEN_H);
    localparam logic [SLACK_W-1:0]     SLACK_RESET = SLACK_W'(600);
    localparam logic [CNT_W-1:0]       CNT_MAX     = CNT_W'(MAX_RECTS);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_MARK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_AREA,
        ST_SCAN,
        ST_APPEND,
        ST_WIDEN,
        ST_READ,
        ST_DONE
    } state_t;

    // One stored rectangle, right and bottom exclusive.
    typedef struct packed {
        logic [EDGE_W-1:0] x0;
        logic [EDGE_W-1:0] y0;
        logic [EDGE_W-1:0] x1;
        logic [EDGE_W-1:0] y1;
    } box_t;

    // Access to the rectangle memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        box_t             wdata;
    } ram_req_t;

    // One result word.
    typedef struct packed {
        logic              entry_valid;
        box_t              entry;
        logic [CNT_W-1:0]  rect_count;
        logic              all_dirty;
        logic [AREA_W-1:0] total_area;
    } res_t;

endpackage

@@ hdl/dirty_rectangle_merger_top.sv @@
// Dirty rectangle merger: one command word in, one result word out, one at a time.
// Clear, mark and an add ignored while the whole screen is dirty go straight to the result;
// a read passes the read state, and an add clamps, then is clipped away or sizes and scans
// the held entries and merges into one, appends, or widens entry 0 when the table of 16 is full.
// A new word is accepted only after the previous result has entered the output register.
// Reset clears the count, the all-dirty flag and the area; the slack resets to 600.
module dirty_rectangle_merger_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic signed [drm_pkg::IN_W-1:0]   left,
    input  logic signed [drm_pkg::IN_W-1:0]   top,
    input  logic signed [drm_pkg::IN_W-1:0]   right,
    input  logic signed [drm_pkg::IN_W-1:0]   bottom,
    input  logic [drm_pkg::IDX_W-1:0]         entry_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              entry_valid,
    output logic [drm_pkg::EDGE_W-1:0]        entry_left,
    output logic [drm_pkg::EDGE_W-1:0]        entry_top,
    output logic [drm_pkg::EDGE_W-1:0]        entry_right,
    output logic [drm_pkg::EDGE_W-1:0]        entry_bottom,
    output logic [drm_pkg::CNT_W-1:0]         rect_count,
    output logic                              all_dirty,
    output logic [drm_pkg::AREA_W-1:0]        total_area,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drm_pkg::SLACK_W-1:0]       cfg_data
);

    logic [drm_pkg::SLACK_W-1:0] slack_reg;
    logic                        out_valid_reg;
    drm_pkg::res_t               out_res_reg;

    logic                        res_valid;
    logic                        res_ready;
    drm_pkg::res_t               res;
    drm_pkg::ram_req_t           ram_req;
    logic [drm_pkg::BOX_W-1:0]   ram_rdata;

    // Merge slack register, writable at any time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg <= drm_pkg::SLACK_RESET;
        end
        else if (cfg_valid)
        begin
            slack_reg <= cfg_data;
        end
    end

    drm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .left        (left),
        .top         (top),
        .right       (right),
        .bottom      (bottom),
        .entry_index (entry_index),
        .slack       (slack_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rdata   (drm_pkg::box_t'(ram_rdata))
    );

    drm_ram #(
        .WIDTH (drm_pkg::BOX_W),
        .DEPTH (drm_pkg::MAX_RECTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: the sequencer may take a new word while a result waits.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_valid  = out_res_reg.entry_valid;
    assign entry_left   = out_res_reg.entry.x0;
    assign entry_top    = out_res_reg.entry.y0;
    assign entry_right  = out_res_reg.entry.x1;
    assign entry_bottom = out_res_reg.entry.y1;
    assign rect_count   = out_res_reg.rect_count;
    assign all_dirty    = out_res_reg.all_dirty;
    assign total_area   = out_res_reg.total_area;

endmodule

@@ hdl/drm_ram.sv @@
module drm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/drm_eval.sv @@
module drm_eval (
    input  drm_pkg::box_t                      entry,
    input  drm_pkg::box_t                      nbox,
    input  logic [drm_pkg::EAREA_W-1:0]        n_area,
    input  logic [drm_pkg::SLACK_W-1:0]        slack,
    output drm_pkg::box_t                      ubox,
    output logic [drm_pkg::EAREA_W-1:0]        b_area,
    output logic [drm_pkg::EAREA_W-1:0]        u_area,
    output logic                               match
);

    logic [drm_pkg::LIMIT_W-1:0] limit;

    // Bounding union of the stored entry and the new rectangle.
    always_comb
    begin
        ubox.x0 = (entry.x0 < nbox.x0) ? entry.x0 : nbox.x0;
        ubox.y0 = (entry.y0 < nbox.y0) ? entry.y0 : nbox.y0;
        ubox.x1 = (entry.x1 > nbox.x1) ? entry.x1 : nbox.x1;
        ubox.y1 = (entry.y1 > nbox.y1) ? entry.y1 : nbox.y1;
    end

    // Areas of the entry and of the union; both edges are ordered.
    assign b_area = drm_pkg::EAREA_W'(entry.x1 - entry.x0)
                  * drm_pkg::EAREA_W'(entry.y1 - entry.y0);
    assign u_area = drm_pkg::EAREA_W'(ubox.x1 - ubox.x0)
                  * drm_pkg::EAREA_W'(ubox.y1 - ubox.y0);

    // Merge when the union costs no more than both areas plus the slack.
    assign limit = drm_pkg::LIMIT_W'(b_area) + drm_pkg::LIMIT_W'(n_area)
                 + drm_pkg::LIMIT_W'(slack);
    assign match = (drm_pkg::LIMIT_W'(u_area) <= limit);

endmodule

@@ hdl/drm_seq.sv @@
module drm_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic signed [drm_pkg::IN_W-1:0]   left,
    input  logic signed [drm_pkg::IN_W-1:0]   top,
    input  logic signed [drm_pkg::IN_W-1:0]   right,
    input  logic signed [drm_pkg::IN_W-1:0]   bottom,
    input  logic [drm_pkg::IDX_W-1:0]         entry_index,
    input  logic [drm_pkg::SLACK_W-1:0]       slack,
    output logic                              res_valid,
    input  logic                              res_ready,
    output drm_pkg::res_t                     res,
    output drm_pkg::ram_req_t                 ram_req,
    input  drm_pkg::box_t                     ram_rdata
);

    drm_pkg::state_t state_reg, state_next;

    logic [drm_pkg::CNT_W-1:0]  count_reg;
    logic                       whole_reg;
    logic [drm_pkg::AREA_W-1:0] sum_reg;

    logic signed [drm_pkg::IN_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [drm_pkg::IDX_W-1:0]       idx_reg;
    logic [drm_pkg::IDX_W-1:0]       chk_reg;
    drm_pkg::box_t                   nbox_reg;
    drm_pkg::box_t                   e0_reg;
    logic [drm_pkg::EAREA_W-1:0]     n_area_reg;
    logic                            res_ev_reg;
    drm_pkg::box_t                   res_ent_reg;

    drm_pkg::op_t op_in;

    logic signed [drm_pkg::IN_W-1:0] x0c, y0c, x1c, y1c;
    logic                            clip_empty;
    logic [drm_pkg::CNT_W-1:0]       chk_succ;
    logic                            more;
    logic                            rd_hit;

    drm_pkg::box_t               ev_entry;
    drm_pkg::box_t               ev_ubox;
    logic [drm_pkg::EAREA_W-1:0] ev_b_area, ev_u_area;
    logic                        ev_match;
    logic [drm_pkg::AREA_W-1:0]  sum_grow;

    assign op_in = drm_pkg::op_t'(opcode);

    // Clip the incoming rectangle to the screen.
    always_comb
    begin
        x0c = left_reg[drm_pkg::IN_W-1] ? '0 : left_reg;
        y0c = top_reg[drm_pkg::IN_W-1] ? '0 : top_reg;
        x1c = (right_reg > drm_pkg::SCREEN_W_S) ? drm_pkg::SCREEN_W_S : right_reg;
        y1c = (bottom_reg > drm_pkg::SCREEN_H_S) ? drm_pkg::SCREEN_H_S : bottom_reg;
        clip_empty = (x1c <= x0c) || (y1c <= y0c);
    end

    // Scan bookkeeping and read hit test.
    assign chk_succ = drm_pkg::CNT_W'(chk_reg) + drm_pkg::CNT_W'(1);
    assign more     = (chk_succ < count_reg);
    assign rd_hit   = !whole_reg && (drm_pkg::CNT_W'(idx_reg) < count_reg);

    // The shared union unit sees the memory word, or entry 0 when widening.
    assign ev_entry = (state_reg == drm_pkg::ST_WIDEN) ? e0_reg : ram_rdata;

    drm_eval u_eval (
        .entry  (ev_entry),
        .nbox   (nbox_reg),
        .n_area (n_area_reg),
        .slack  (slack),
        .ubox   (ev_ubox),
        .b_area (ev_b_area),
        .u_area (ev_u_area),
        .match  (ev_match)
    );

    assign sum_grow = sum_reg + drm_pkg::AREA_W'(ev_u_area) - drm_pkg::AREA_W'(ev_b_area);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_in)
                        drm_pkg::OP_ADD:
                            state_next = whole_reg ? drm_pkg::ST_DONE : drm_pkg::ST_CLAMP;
                        drm_pkg::OP_READ:
                            state_next = drm_pkg::ST_READ;
                        default:
                            state_next = drm_pkg::ST_DONE;
                    endcase
                end
            end
            drm_pkg::ST_CLAMP:
                state_next = clip_empty ? drm_pkg::ST_DONE : drm_pkg::ST_AREA;
            drm_pkg::ST_AREA:
                state_next = (count_reg == '0) ? drm_pkg::ST_APPEND : drm_pkg::ST_SCAN;
            drm_pkg::ST_SCAN:
            begin
                if (ev_match)
                begin
                    state_next = drm_pkg::ST_DONE;
                end
                else if (!more)
                begin
                    state_next = (count_reg < drm_pkg::CNT_MAX) ? drm_pkg::ST_APPEND
                                                                : drm_pkg::ST_WIDEN;
                end
            end
            drm_pkg::ST_APPEND,
            drm_pkg::ST_WIDEN,
            drm_pkg::ST_READ:
                state_next = drm_pkg::ST_DONE;
            drm_pkg::ST_DONE:
                state_next = res_ready ? drm_pkg::ST_IDLE : drm_pkg::ST_DONE;
            default:
                state_next = drm_pkg::ST_IDLE;
        endcase
    end

    // Handshakes and memory access for each state.
    always_comb
    begin
        in_ready      = (state_reg == drm_pkg::ST_IDLE);
        res_valid     = (state_reg == drm_pkg::ST_DONE);
        ram_req.we    = 1'b0;
        ram_req.waddr = '0;
        ram_req.wdata = ev_ubox;
        ram_req.raddr = '0;
        case (state_reg)
            drm_pkg::ST_IDLE:
                ram_req.raddr = entry_index;
            drm_pkg::ST_SCAN:
            begin
                ram_req.raddr = chk_succ[drm_pkg::IDX_W-1:0];
                ram_req.we    = ev_match;
                ram_req.waddr = chk_reg;
            end
            drm_pkg::ST_APPEND:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_reg[drm_pkg::IDX_W-1:0];
                ram_req.wdata = nbox_reg;
            end
            drm_pkg::ST_WIDEN:
                ram_req.we    = 1'b1;
            default:
                ram_req.we    = 1'b0;
        endcase
    end

    // Control state: state, count, all-dirty flag and running area.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drm_pkg::ST_IDLE;
            count_reg <= '0;
            whole_reg <= 1'b0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                drm_pkg::ST_IDLE:
                begin
                    if (in_valid && (op_in == drm_pkg::OP_CLEAR))
                    begin
                        count_reg <= '0;
                        whole_reg <= 1'b0;
                        sum_reg   <= '0;
                    end
                    else if (in_valid && (op_in == drm_pkg::OP_MARK))
                    begin
                        count_reg <= '0;
                        whole_reg <= 1'b1;
                        sum_reg   <= '0;
                    end
                end
                drm_pkg::ST_SCAN:
                begin
                    if (ev_match)
                    begin
                        sum_reg <= sum_grow;
                    end
                end
                drm_pkg::ST_APPEND:
                begin
                    count_reg <= count_reg + drm_pkg::CNT_W'(1);
                    sum_reg   <= sum_reg + drm_pkg::AREA_W'(n_area_reg);
                end
                drm_pkg::ST_WIDEN:
                    sum_reg <= sum_grow;
                default:
                    sum_reg <= sum_reg;
            endcase
        end
    end

    // Word and working registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            drm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    left_reg    <= left;
                    top_reg     <= top;
                    right_reg   <= right;
                    bottom_reg  <= bottom;
                    idx_reg     <= entry_index;
                    res_ev_reg  <= 1'b0;
                    res_ent_reg <= '0;
                end
            end
            drm_pkg::ST_CLAMP:
            begin
                nbox_reg.x0 <= x0c[drm_pkg::EDGE_W-1:0];
                nbox_reg.y0 <= y0c[drm_pkg::EDGE_W-1:0];
                nbox_reg.x1 <= x1c[drm_pkg::EDGE_W-1:0];
                nbox_reg.y1 <= y1c[drm_pkg::EDGE_W-1:0];
            end
            drm_pkg::ST_AREA:
            begin
                n_area_reg <= drm_pkg::EAREA_W'(nbox_reg.x1 - nbox_reg.x0)
                            * drm_pkg::EAREA_W'(nbox_reg.y1 - nbox_reg.y0);
                chk_reg    <= '0;
            end
            drm_pkg::ST_SCAN:
            begin
                if (chk_reg == '0)
                begin
                    e0_reg <= ram_rdata;
                end
                if (!ev_match)
                begin
                    chk_reg <= chk_succ[drm_pkg::IDX_W-1:0];
                end
            end
            drm_pkg::ST_READ:
            begin
                res_ev_reg  <= rd_hit;
                res_ent_reg <= rd_hit ? ram_rdata : '0;
            end
            default:
                chk_reg <= chk_reg;
        endcase
    end

    // Result word from the state after this command.
    always_comb
    begin
        res.entry_valid = res_ev_reg;
        res.entry       = res_ent_reg;
        res.rect_count  = count_reg;
        res.all_dirty   = whole_reg;
        res.total_area  = whole_reg ? drm_pkg::SCREEN_AREA : sum_reg;
    end

    // The table never holds more rectangles than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= drm_pkg::CNT_MAX)
        else $error("rectangle count beyond table depth");

    // Marking the whole screen leaves an empty table and no summed area.
    assert property (@(posedge clk) disable iff (!rst_n)
        whole_reg |-> (count_reg == '0) && (sum_reg == '0))
        else $error("whole screen marked with entries held");

    // The scan only looks at entries that are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drm_pkg::ST_SCAN) |-> (drm_pkg::CNT_W'(chk_reg) < count_reg))
        else $error("scan beyond held entries");

    // An append grows the table by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drm_pkg::ST_APPEND) |=>
            (count_reg == $past(count_reg) + drm_pkg::CNT_W'(1)))
        else $error("append did not grow the table");

endmodule
